FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("lcm assertion failed");
`define LCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lcm implication failed");
`else
`define LCM_ASSERT(lbl, clk, rstn, prop)
`define LCM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/lcm_pkg.sv
package lcm_pkg;

	localparam int CHAR_W        = 8;
	localparam int TOKEN_CHARS   = 8;
	localparam int COMMAND_CHARS = 8;
	localparam int WORD_W        = TOKEN_CHARS * CHAR_W;
	localparam int TLEN_W        = 7;
	localparam int CNT_W         = 3;
	localparam int IDX_W         = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_LO    = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HI    = 8'h7E;
	localparam logic [CHAR_W-1:0] NUL_CHAR    = 8'h00;
	localparam logic [15:0]       LINE_END_RST = 16'h0A0D;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_END  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD0     = 3'd2;

	typedef enum logic [2:0] {
		PH_BEFORE = 3'b001,
		PH_IN     = 3'b010,
		PH_AFTER  = 3'b100
	} phase_t;

	// finished line handed from front to back
	typedef struct packed {
		logic [WORD_W-1:0] token_chars;
		logic [TLEN_W-1:0] token_len;
	} line_rec_t;

	// strncmp-style compare, stops at the first NUL of the word
	function automatic logic word_match(input logic [WORD_W-1:0] word,
			input logic [WORD_W-1:0] tok);
		logic done;
		logic res;
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] t;
		done = 1'b0;
		res  = 1'b1;
		for (int i = 0; i < COMMAND_CHARS; i++) begin
			c = word[i*CHAR_W +: CHAR_W];
			t = tok[i*CHAR_W +: CHAR_W];
			if (!done) begin
				if (c != t) begin
					res  = 1'b0;
					done = 1'b1;
				end else if (c == NUL_CHAR) begin
					done = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/lcm_front.sv
`include "assert_macros.svh"

module lcm_front import lcm_pkg::*; #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAR_W-1:0]   in_byte,
	input  logic [15:0]         line_end_chars,
	input  logic                q_full,
	output logic                q_push,
	output line_rec_t           q_rec
);

	localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

	logic [FILL_W-1:0] line_fill_q;
	phase_t            phase_q;
	logic [WORD_W-1:0] token_chars_q;
	logic [TLEN_W-1:0] token_count_q;

	logic [CHAR_W-1:0] term;
	logic [CHAR_W-1:0] skip;
	logic              accept;
	logic              is_term;
	logic              store;

	assign term     = line_end_chars[7:0];
	assign skip     = line_end_chars[15:8];
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_term  = accept && (in_byte != skip) && (in_byte == term);
	assign store    = accept && (in_byte != skip) && (in_byte != term)
		&& (in_byte >= PRINT_LO) && (in_byte <= PRINT_HI)
		&& (line_fill_q < FILL_W'(LINE_CAPACITY));

	assign q_push            = is_term && (phase_q != PH_BEFORE);
	assign q_rec.token_chars = token_chars_q;
	assign q_rec.token_len   = token_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_fill_q   <= '0;
			phase_q       <= PH_BEFORE;
			token_chars_q <= '0;
			token_count_q <= '0;
		end else if (is_term) begin
			line_fill_q   <= '0;
			phase_q       <= PH_BEFORE;
			token_chars_q <= '0;
			token_count_q <= '0;
		end else if (store) begin
			line_fill_q <= line_fill_q + FILL_W'(1);
			if (in_byte == SPACE_CHAR) begin
				if (phase_q == PH_IN) begin
					phase_q <= PH_AFTER;
				end
			end else if (phase_q != PH_AFTER) begin
				phase_q <= PH_IN;
				if (token_count_q < TLEN_W'(TOKEN_CHARS)) begin
					token_chars_q[token_count_q[2:0]*CHAR_W +: CHAR_W] <= in_byte;
				end
				token_count_q <= token_count_q + TLEN_W'(1);
			end
		end
	end

	`LCM_ASSERT_IMP(a_empty_token, clk, arst_n, phase_q == PH_BEFORE, token_count_q == '0)
	`LCM_ASSERT(a_fill_bound, clk, arst_n, line_fill_q <= FILL_W'(LINE_CAPACITY))

endmodule

FILE: rtl/core/lcm_fifo.sv
`include "assert_macros.svh"

module lcm_fifo import lcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  line_rec_t push_rec,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output line_rec_t head
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	line_rec_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_FW-1:0]  count_q;

	assign full  = (count_q == CNT_FW'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_FW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_FW'(1);
			end
		end
	end

	`LCM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`LCM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)

endmodule

FILE: rtl/core/lcm_back.sv
`include "assert_macros.svh"

module lcm_back import lcm_pkg::*; #(
	parameter int COMMAND_SLOTS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  line_rec_t                            q_head,
	output logic                                 q_pop,
	input  logic [CNT_W-1:0]                     command_count,
	input  logic [COMMAND_SLOTS-1:0][WORD_W-1:0] command_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic [IDX_W-1:0]                     command_index,
	output logic [WORD_W-1:0]                    token_head,
	output logic [TLEN_W-1:0]                    token_length
);

	logic              valid_q;
	logic              hit_q;
	logic [IDX_W-1:0]  index_q;
	logic [WORD_W-1:0] head_q;
	logic [TLEN_W-1:0] len_q;

	logic              found;
	logic [IDX_W-1:0]  found_idx;

	// lowest active slot that matches wins
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < COMMAND_SLOTS; i++) begin
			if (!found && (CNT_W'(i) < command_count)
					&& word_match(command_word[i], q_head.token_chars)) begin
				found     = 1'b1;
				found_idx = IDX_W'(i);
			end
		end
	end

	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hit_q   <= found;
			index_q <= found_idx;
			head_q  <= q_head.token_chars;
			len_q   <= q_head.token_len;
		end
	end

	assign out_valid     = valid_q;
	assign hit           = hit_q;
	assign command_index = index_q;
	assign token_head    = head_q;
	assign token_length  = len_q;

	`LCM_ASSERT_IMP(a_miss_index_zero, clk, arst_n, valid_q && !hit_q, index_q == '0)

endmodule

FILE: rtl/core/line_command_keyword_matcher_unit.sv
// Path: a terminator beat is written into the line queue; the back end pops it when its
//   result register is free or being taken, and that register drives m_axis_tvalid.
// Throughput: one input beat per cycle; s_axis_tready drops only while the 4-deep
//   line queue between front and back is full (results backed up on m_axis).
// Reset (arst_n low, async): line state, queue and output valid cleared; registers
//   return to terminator CR / ignore LF, zero command slots, zero words.
module line_command_keyword_matcher_unit import lcm_pkg::*; #(
	parameter int LINE_CAPACITY = 64,
	parameter int COMMAND_SLOTS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input byte stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
	// match results, one beat per line holding a token
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [79:0]           m_axis_tdata,   // [2:0] command_index, [66:3] token_head,
	                                              // [73:67] token_length, [79:74] zero
	output logic                  m_axis_tuser,   // [0] hit
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// register file
	logic [15:0]                          line_end_q;
	logic [CNT_W-1:0]                     cmd_count_q;
	logic [COMMAND_SLOTS-1:0][WORD_W-1:0] cmd_word_q;

	// front -> queue -> back
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;
	line_rec_t q_in;
	line_rec_t q_head;

	logic              res_hit;
	logic [IDX_W-1:0]  res_idx;
	logic [WORD_W-1:0] res_head;
	logic [TLEN_W-1:0] res_len;

	// Count above the slot number needs no clamp: slots past the end do not exist,
	// so the back end only scans what is built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_end_q  <= LINE_END_RST;
			cmd_count_q <= '0;
			cmd_word_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LINE_END) begin
				line_end_q <= cfg_data[15:0];
			end
			if (cfg_index == CFG_CMD_COUNT) begin
				cmd_count_q <= cfg_data[CNT_W-1:0];
			end
			for (int i = 0; i < COMMAND_SLOTS; i++) begin
				if (cfg_index == CFG_IDX_W'(CFG_WORD0 + CFG_IDX_W'(i))) begin
					cmd_word_q[i] <= cfg_data[WORD_W-1:0];
				end
			end
		end
	end

	// front: tracks the line and its first token, queues finished lines that hold a token
	lcm_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_byte       (s_axis_tdata),
		.line_end_chars(line_end_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_rec         (q_in)
	);

	lcm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_rec(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	// back: compares the token against the active slots in parallel, holds the result beat
	lcm_back #(
		.COMMAND_SLOTS(COMMAND_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.command_count(cmd_count_q),
		.command_word (cmd_word_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.hit          (res_hit),
		.command_index(res_idx),
		.token_head   (res_head),
		.token_length (res_len)
	);

	assign m_axis_tuser = res_hit;
	assign m_axis_tdata = {6'b0, res_len, res_head, res_idx};

endmodule

FILE: tb/sv/lcm_result_checker.sv
`timescale 1ns / 1ps

// Watches the byte stream and config writes, tracks the line state, and scores
// every result beat against the oldest predicted match.
module lcm_result_checker import lcm_pkg::*; #(
	parameter int LINE_CAPACITY = 64,
	parameter int COMMAND_SLOTS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [79:0]           m_axis_tdata,
	input  logic                  m_axis_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    error_count,
	output int                    pending_matches,
	output int                    results_checked,
	output int                    hits_seen
);

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  slot;
		logic [WORD_W-1:0] head;
		logic [TLEN_W-1:0] length;
	} match_t;

	match_t expected_matches[$];

	// register copy
	logic [CHAR_W-1:0] term_char;
	logic [CHAR_W-1:0] skip_char;
	logic [CNT_W-1:0]  slots_used;
	logic [WORD_W-1:0] cmd_words[COMMAND_SLOTS];

	// line state
	int                fill_level;
	phase_t            scan_phase;
	logic [WORD_W-1:0] head_chars;
	logic [TLEN_W-1:0] token_len;

	function automatic logic word_equal(input logic [WORD_W-1:0] word,
			input logic [WORD_W-1:0] tok);
		for (int k = 0; k < COMMAND_CHARS; k++) begin
			if (word[k*CHAR_W +: CHAR_W] != tok[k*CHAR_W +: CHAR_W])
				return 1'b0;
			if (word[k*CHAR_W +: CHAR_W] == NUL_CHAR)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic clear_line();
		fill_level = 0;
		scan_phase = PH_BEFORE;
		head_chars = '0;
		token_len  = '0;
	endtask

	task automatic absorb_byte(input logic [CHAR_W-1:0] b);
		match_t m;
		int     limit;
		if (b == skip_char)
			return;
		if (b == term_char) begin
			if (scan_phase != PH_BEFORE) begin
				m.hit  = 1'b0;
				m.slot = '0;
				limit  = (slots_used > COMMAND_SLOTS) ? COMMAND_SLOTS : slots_used;
				for (int s = 0; s < limit; s++) begin
					if (!m.hit && word_equal(cmd_words[s], head_chars)) begin
						m.hit  = 1'b1;
						m.slot = IDX_W'(s);
					end
				end
				m.head   = head_chars;
				m.length = token_len;
				expected_matches.push_back(m);
			end
			clear_line();
			return;
		end
		if (b >= PRINT_LO && b <= PRINT_HI && fill_level < LINE_CAPACITY) begin
			fill_level++;
			if (b == SPACE_CHAR) begin
				if (scan_phase == PH_IN)
					scan_phase = PH_AFTER;
			end else if (scan_phase != PH_AFTER) begin
				scan_phase = PH_IN;
				if (token_len < TOKEN_CHARS)
					head_chars[token_len*CHAR_W +: CHAR_W] = b;
				token_len++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_t            want;
		logic [IDX_W-1:0]  got_slot;
		logic [WORD_W-1:0] got_head;
		logic [TLEN_W-1:0] got_len;
		if (!arst_n) begin
			term_char  = LINE_END_RST[7:0];
			skip_char  = LINE_END_RST[15:8];
			slots_used = '0;
			for (int s = 0; s < COMMAND_SLOTS; s++)
				cmd_words[s] = '0;
			clear_line();
			expected_matches.delete();
			error_count     = 0;
			pending_matches = 0;
			results_checked = 0;
			hits_seen       = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LINE_END) begin
					term_char = cfg_data[7:0];
					skip_char = cfg_data[15:8];
				end else if (cfg_index == CFG_CMD_COUNT) begin
					slots_used = cfg_data[CNT_W-1:0];
				end else begin
					cmd_words[cfg_index - CFG_WORD0] = cfg_data;
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				absorb_byte(s_axis_tdata);

			if (m_axis_tvalid && m_axis_tready) begin
				got_slot = m_axis_tdata[IDX_W-1:0];
				got_head = m_axis_tdata[IDX_W +: WORD_W];
				got_len  = m_axis_tdata[IDX_W+WORD_W +: TLEN_W];
				if (expected_matches.size() == 0) begin
					error_count++;
					$error("result beat with nothing expected: tdata=%h tuser=%b",
						m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_matches.pop_front();
					results_checked++;
					if (m_axis_tuser)
						hits_seen++;
					if (m_axis_tuser != want.hit) begin
						error_count++;
						$error("hit mismatch: expected %0d, got %0d", want.hit, m_axis_tuser);
					end
					if (got_slot != want.slot) begin
						error_count++;
						$error("command_index mismatch: expected %0d, got %0d",
							want.slot, got_slot);
					end
					if (got_head != want.head) begin
						error_count++;
						$error("token_head mismatch: expected %h, got %h", want.head, got_head);
					end
					if (got_len != want.length) begin
						error_count++;
						$error("token_length mismatch: expected %0d, got %0d",
							want.length, got_len);
					end
				end
			end
			pending_matches = expected_matches.size();
		end
	end

endmodule

FILE: tb/sv/line_command_keyword_matcher_unit_test.sv
`timescale 1ns / 1ps

// Top of the matcher bench: clock, reset, byte stimulus, sink backpressure and
// the verdict. All scoring lives in lcm_result_checker.
module line_command_keyword_matcher_unit_test import lcm_pkg::*; ();

	localparam int LINE_CAPACITY = 64;
	localparam int COMMAND_SLOTS = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 8;

	localparam logic [7:0] CR_CHAR = 8'h0D;
	localparam logic [7:0] LF_CHAR = 8'h0A;

	// shapes of generated lines
	typedef enum int {
		LN_WORD,    // token copied from a programmed slot
		LN_EXTEND,  // slot text plus extra characters
		LN_PREFIX,  // leading part of a slot text
		LN_RANDOM,  // random printable token
		LN_LONG,    // long run that often overflows the line
		LN_BLANK    // empty or spaces only
	} line_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [7:0] in_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [79:0]           m_axis_tdata;   // [2:0] command_index, [66:3] token_head,
	                                       // [73:67] token_length, [79:74] zero
	logic                  m_axis_tuser;   // [0] hit
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int error_count;
	int pending_matches;
	int results_checked;
	int hits_seen;

	int cycle_count;
	int bytes_sent;
	int src_idle_pct;    // chance per cycle that the sender holds off
	int sink_stall_pct;  // chance per cycle that the sink drops tready

	// stimulus-side copy of what is programmed, used to aim tokens at slots
	logic [15:0]       line_end;
	logic [WORD_W-1:0] slot_words[COMMAND_SLOTS];

	line_command_keyword_matcher_unit #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.COMMAND_SLOTS(COMMAND_SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lcm_result_checker #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.COMMAND_SLOTS(COMMAND_SLOTS)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.error_count    (error_count),
		.pending_matches(pending_matches),
		.results_checked(results_checked),
		.hits_seen      (hits_seen)
	);

	always #2 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends up here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sink backpressure, redrawn every cycle
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic logic [7:0] rand_glyph();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	// Command text: mostly short printable words, some full 8-char ones, some
	// with junk after a NUL (compare must stop at the NUL), some raw bits.
	function automatic logic [WORD_W-1:0] make_word();
		logic [WORD_W-1:0] w;
		int                n;
		int                pick;
		w    = '0;
		pick = $urandom_range(9);
		n    = (pick == 2) ? 8 : $urandom_range(1, 8);
		for (int k = 0; k < n; k++)
			w[k*CHAR_W +: CHAR_W] = rand_glyph();
		if (pick == 1) begin
			for (int k = n + 1; k < TOKEN_CHARS; k++)
				w[k*CHAR_W +: CHAR_W] = rand_glyph();
		end else if (pick == 0) begin
			w = {$urandom, $urandom};
		end
		return w;
	endfunction

	function automatic line_kind_t pick_kind();
		int r;
		r = $urandom_range(19);
		if (r < 6)       return LN_WORD;
		else if (r < 9)  return LN_EXTEND;
		else if (r < 11) return LN_PREFIX;
		else if (r < 17) return LN_RANDOM;
		else if (r < 18) return LN_LONG;
		else             return LN_BLANK;
	endfunction

	// One beat on the input stream. Called right after a falling edge; returns
	// right after the falling edge that follows the accepting rising edge.
	// tvalid is left high so back-to-back beats need no dip; idle() lowers it.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++)
			send_byte(s[k]);
	endtask

	// drop tvalid and wait for every predicted match, plus pipeline slack for
	// bytes that only touched line state
	task automatic idle();
		s_axis_tvalid = 1'b0;
		while (pending_matches != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// rewrite every register; with extremes set, slot 0 gets all ones and
	// slot 1 all zeros
	task automatic program_setting(input logic [15:0] ends, input logic [2:0] count,
			input logic extremes);
		line_end = ends;
		cfg_write(CFG_LINE_END, CFG_DATA_W'(ends));
		cfg_write(CFG_CMD_COUNT, CFG_DATA_W'(count));
		for (int s = 0; s < COMMAND_SLOTS; s++) begin
			slot_words[s] = make_word();
			if (extremes && s == 0) slot_words[s] = '1;
			if (extremes && s == 1) slot_words[s] = '0;
			cfg_write(CFG_WORD0 + CFG_IDX_W'(s), slot_words[s]);
		end
	endtask

	task automatic send_line(input line_kind_t kind);
		logic [7:0]        text[$];
		logic [WORD_W-1:0] w;
		int                n;
		w = slot_words[$urandom_range(COMMAND_SLOTS - 1)];
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) text.push_back(SPACE_CHAR);
		case (kind)
			LN_WORD, LN_EXTEND, LN_PREFIX: begin
				n = 0;
				while (n < TOKEN_CHARS && w[n*CHAR_W +: CHAR_W] != NUL_CHAR)
					n++;
				if (kind == LN_PREFIX && n > 1)
					n = $urandom_range(1, n - 1);
				for (int k = 0; k < n; k++)
					text.push_back(w[k*CHAR_W +: CHAR_W]);
				if (kind == LN_EXTEND)
					repeat ($urandom_range(1, 6)) text.push_back(rand_glyph());
			end
			LN_RANDOM: begin
				repeat ($urandom_range(1, 12)) text.push_back(rand_glyph());
			end
			LN_LONG: begin
				// mostly glyphs with scattered spaces, 60 to 80 bytes, often past the line capacity
				repeat ($urandom_range(60, 80))
					text.push_back(($urandom_range(9) == 0) ? SPACE_CHAR : rand_glyph());
			end
			default: begin
				repeat ($urandom_range(3)) text.push_back(SPACE_CHAR);
			end
		endcase
		// optional argument after the command
		if (kind != LN_LONG && kind != LN_BLANK && $urandom_range(1) == 1) begin
			text.push_back(SPACE_CHAR);
			repeat ($urandom_range(1, 6)) text.push_back(rand_glyph());
		end
		// stray bytes of any value, including control and high codes
		foreach (text[k]) begin
			if ($urandom_range(15) == 0)
				send_byte(8'($urandom_range(255)));
			send_byte(text[k]);
		end
		send_byte(line_end[7:0]);
	endtask

	initial begin
		int budget;
		int start;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		bytes_sent     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		line_end       = LINE_END_RST;
		for (int s = 0; s < COMMAND_SLOTS; s++)
			slot_words[s] = '0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// reset settings: CR ends a line, LF ignored, no slots -> default case
		send_text("a");
		send_byte(CR_CHAR);
		idle();

		// slots: "go", "stop", "ab" with junk after its NUL, full 8-char word,
		// all ones, all zeros; count 7 leaves only the six built slots active
		line_end = LINE_END_RST;
		cfg_write(CFG_LINE_END, CFG_DATA_W'(LINE_END_RST));
		cfg_write(CFG_CMD_COUNT, CFG_DATA_W'(7));
		slot_words[0] = 64'h0000_0000_0000_6F67;
		slot_words[1] = 64'h0000_0000_706F_7473;
		slot_words[2] = 64'h0000_0079_7800_6261;
		slot_words[3] = 64'h4847_4645_4443_4241;
		slot_words[4] = '1;
		slot_words[5] = '0;
		for (int s = 0; s < COMMAND_SLOTS; s++)
			cfg_write(CFG_WORD0 + CFG_IDX_W'(s), slot_words[s]);

		send_byte(CR_CHAR);                 // empty line, no result
		send_text(" ");
		send_byte(CR_CHAR);                 // spaces only, no result
		send_text("go");
		send_byte(CR_CHAR);
		// control and high bytes dropped, LF skipped; trailing ~ makes the token miss "stop"
		send_text(" s");
		send_byte(8'h00);
		send_text("t");
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h1F);
		send_byte(LF_CHAR);
		send_text("op~");
		send_byte(CR_CHAR);
		send_text("ab");                    // matches word ending at its NUL
		send_byte(CR_CHAR);
		send_text("ABCDEFGH~");             // long token, first 8 match slot 3
		send_byte(CR_CHAR);

		// --- random part: one setting and one idling mode per phase ---
		for (int p = 0; p < PHASES; p++) begin
			idle();
			case (p)
				0: program_setting(16'h0A0D, 3'd6, 1'b0);
				1: program_setting(16'h7E3B, 3'd3, 1'b0);  // printable terminator
				2: program_setting(16'hFFFF, 3'd7, 1'b0);  // skip == terminator
				3: program_setting(16'hFF00, 3'd0, 1'b0);  // NUL ends the line
				4: program_setting(16'h00FF, 3'd1, 1'b0);
				5: program_setting(16'h200D, 3'd5, 1'b0);  // spaces skipped
				6: program_setting(16'h0A0D, 3'd6, 1'b1);
				default: program_setting(16'h0A0D, 3'd2, 1'b0);
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
				default: begin src_idle_pct = 21; sink_stall_pct = 21; end
			endcase
			// lines never end in phase 2, so keep it short
			budget = (p == 2) ? 30 : 70;
			start  = bytes_sent;
			if (p == 0 || p == 6)
				send_line(LN_LONG);
			while (bytes_sent - start < budget)
				send_line(pick_kind());
		end

		idle();
		repeat (4) @(negedge clk);

		$display("Covered %0d input bytes over %0d settings plus directed lines;",
			bytes_sent, PHASES);
		$display("%0d result beats checked, %0d of them command hits.",
			results_checked, hits_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lcm_pkg.sv
rtl/core/lcm_front.sv
rtl/core/lcm_fifo.sv
rtl/core/lcm_back.sv
rtl/core/line_command_keyword_matcher_unit.sv
tb/sv/lcm_result_checker.sv
tb/sv/line_command_keyword_matcher_unit_test.sv
